>>> sv/dosc_pkg.sv
// ----------------------------------------------------------------------------
// dosc_pkg
// Shared types, constants and the step microcode for the drag oscillator
// midpoint step unit.
// ----------------------------------------------------------------------------
package dosc_pkg;

	localparam int VALUE_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_W    = 2 * VALUE_W + 1;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// Rounding constants: half an LSB of the shifted product
	localparam logic [PROD_W-1:0] RND_FULL = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << FRAC_BITS;

	// Register reset values
	localparam logic [31:0]        RST_DRAG      = 32'd3277;
	localparam logic [31:0]        RST_STIFF     = 32'd65536;
	localparam logic [15:0]        RST_DT        = 16'd655;
	localparam logic signed [31:0] RST_START_POS = 32'sd655360;
	localparam logic signed [31:0] RST_START_VEL = 32'sd65536;
	localparam logic [30:0]        RST_THRESH    = 31'd19661;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_DRAG      = 3'd0;
	localparam logic [2:0] REG_STIFF     = 3'd1;
	localparam logic [2:0] REG_DT        = 3'd2;
	localparam logic [2:0] REG_START_POS = 3'd3;
	localparam logic [2:0] REG_START_VEL = 3'd4;
	localparam logic [2:0] REG_THRESH    = 3'd5;

	localparam int          NUM_OPS = 10;
	localparam logic [3:0]  OP_LAST = 4'(NUM_OPS - 1);

	typedef struct packed {
		logic [31:0]        drag_coef;
		logic [31:0]        stiffness_coef;
		logic [15:0]        time_step;
		logic signed [31:0] start_position;
		logic signed [31:0] start_velocity;
		logic [30:0]        settle_threshold;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		A_DT,
		A_DRAG,
		A_STIFF,
		A_V,
		A_VM
	} a_sel_t;

	typedef enum logic [2:0] {
		B_T,
		B_X,
		B_XM,
		B_V,
		B_VM
	} b_sel_t;

	typedef enum logic [2:0] {
		D_T,
		D_VM,
		D_XM,
		D_V,
		D_X
	} dst_t;

	typedef enum logic [1:0] {
		BS_ZERO,
		BS_T,
		BS_V,
		BS_X
	} base_sel_t;

	typedef struct packed {
		a_sel_t    a_sel;
		b_sel_t    b_sel;
		logic      b_abs;      // B operand is |value| clamped to VAL_MAX
		logic      half_step;  // shift by FRAC_BITS+1 instead of FRAC_BITS
		base_sel_t base_sel;
		logic      sub;        // dest = base - product, else base + product
		dst_t      dst;
	} op_t;

	typedef struct packed {
		logic load_start;
		logic mul_en;
		logic fin_en;
		logic out_load;
		op_t  op;
	} dp_cmd_t;

	// One midpoint step as ten multiply / accumulate operations
	function automatic op_t op_table(input logic [3:0] idx);
		op_t o;
		o = '{A_DT, B_T, 1'b0, 1'b0, BS_ZERO, 1'b0, D_T};
		unique case (idx)
			4'd0: o = '{A_V,     B_V,  1'b1, 1'b0, BS_ZERO, 1'b0, D_T};  // v*|v|
			4'd1: o = '{A_DRAG,  B_T,  1'b0, 1'b0, BS_ZERO, 1'b1, D_T};  // -drag term
			4'd2: o = '{A_STIFF, B_X,  1'b0, 1'b0, BS_T,    1'b1, D_T};  // accel
			4'd3: o = '{A_DT,    B_T,  1'b0, 1'b1, BS_V,    1'b0, D_VM}; // v mid
			4'd4: o = '{A_DT,    B_V,  1'b0, 1'b1, BS_X,    1'b0, D_XM}; // x mid
			4'd5: o = '{A_VM,    B_VM, 1'b1, 1'b0, BS_ZERO, 1'b0, D_T};
			4'd6: o = '{A_DRAG,  B_T,  1'b0, 1'b0, BS_ZERO, 1'b1, D_T};
			4'd7: o = '{A_STIFF, B_XM, 1'b0, 1'b0, BS_T,    1'b1, D_T};  // accel at mid
			4'd8: o = '{A_DT,    B_T,  1'b0, 1'b0, BS_V,    1'b0, D_V};  // new v
			4'd9: o = '{A_DT,    B_VM, 1'b0, 1'b0, BS_X,    1'b0, D_X};  // new x
			default: o = '{A_DT, B_T, 1'b0, 1'b0, BS_ZERO, 1'b0, D_T};
		endcase
		return o;
	endfunction

	function automatic logic [VALUE_W-1:0] mag(input logic signed [VALUE_W-1:0] a);
		return a[VALUE_W-1] ? VALUE_W'(-a) : VALUE_W'(a);
	endfunction

endpackage

>>> sv/drag_oscillator_midpoint_step_unit.sv
// ----------------------------------------------------------------------------
// drag_oscillator_midpoint_step_unit
// Mass-spring oscillator with quadratic drag, one midpoint (RK2) step per
// transaction, signed Q16.16 state with saturating arithmetic.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tdata[0] restart
//  m_axis    out  tdata[31:0] position_out, [63:32] velocity_out, [64] settled
//  apb       in   six registers at 0x00..0x14, write and read back
//
// A step runs through the accept cycle, ten multiply/accumulate operations
// (a multiply state and a finish state each) on the single shared 32x32
// multiplier, and the output load; output valid is registered after the load.
// A restart loads the start values on accept and goes straight to the load.
// Reset loads the start values into the state.
// The next input is taken while a result still waits in the output register;
// the unit then holds with a finished step until m_axis_tready frees it.
// ----------------------------------------------------------------------------
module drag_oscillator_midpoint_step_unit import dosc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] restart
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // [31:0] position_out, [63:32] velocity_out, [64] settled
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t    cfg;
	dp_cmd_t cmd;
	logic    out_free;

	dosc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dosc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.restart       (s_axis_tdata[0]),
		.out_free      (out_free),
		.cmd           (cmd)
	);

	dosc_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg),
		.out_free      (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

>>> sv/dosc_cfg.sv
// ----------------------------------------------------------------------------
// dosc_cfg
// APB register file for the oscillator coefficients and start values.
// ----------------------------------------------------------------------------
module dosc_cfg import dosc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drag_coef        <= RST_DRAG;
			cfg_q.stiffness_coef   <= RST_STIFF;
			cfg_q.time_step        <= RST_DT;
			cfg_q.start_position   <= RST_START_POS;
			cfg_q.start_velocity   <= RST_START_VEL;
			cfg_q.settle_threshold <= RST_THRESH;
		end else if (wr_en) begin
			unique case (idx)
				REG_DRAG:      cfg_q.drag_coef        <= pwdata;
				REG_STIFF:     cfg_q.stiffness_coef   <= pwdata;
				REG_DT:        cfg_q.time_step        <= pwdata[15:0];
				REG_START_POS: cfg_q.start_position   <= $signed(pwdata);
				REG_START_VEL: cfg_q.start_velocity   <= $signed(pwdata);
				REG_THRESH:    cfg_q.settle_threshold <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DRAG:      prdata = cfg_q.drag_coef;
			REG_STIFF:     prdata = cfg_q.stiffness_coef;
			REG_DT:        prdata = {16'b0, cfg_q.time_step};
			REG_START_POS: prdata = cfg_q.start_position;
			REG_START_VEL: prdata = cfg_q.start_velocity;
			REG_THRESH:    prdata = {1'b0, cfg_q.settle_threshold};
			default:       prdata = '0;
		endcase
	end

endmodule

>>> sv/dosc_ctrl.sv
// ----------------------------------------------------------------------------
// dosc_ctrl
// Sequencer: steps the datapath through the ten operations of a midpoint
// step, or a reload on restart, then hands the result to the output register.
// ----------------------------------------------------------------------------
module dosc_ctrl import dosc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_axis_tvalid,
	output logic    s_axis_tready,
	input  logic    restart,
	input  logic    out_free,
	output dp_cmd_t cmd
);

	state_t     state_q, state_d;
	logic [3:0] op_q;
	logic       accept;

	assign accept = s_axis_tvalid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= '0;
		end else begin
			state_q <= state_d;
			if (accept)
				op_q <= '0;
			else if (state_q == ST_FIN)
				op_q <= op_q + 4'd1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid)
					state_d = restart ? ST_DONE : ST_MUL;
			end
			ST_MUL: state_d = ST_FIN;
			ST_FIN: state_d = (op_q == OP_LAST) ? ST_DONE : ST_MUL;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready  = (state_q == ST_IDLE);
		cmd.load_start = accept && restart;
		cmd.mul_en     = (state_q == ST_MUL);
		cmd.fin_en     = (state_q == ST_FIN);
		cmd.out_load   = (state_q == ST_DONE) && out_free;
		cmd.op         = op_table(op_q);
	end

endmodule

>>> sv/dosc_dp.sv
// ----------------------------------------------------------------------------
// dosc_dp
// Datapath: state registers, one shared 32x32 multiplier with rounding,
// saturating accumulate and the output register.
// ----------------------------------------------------------------------------
module dosc_dp import dosc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  cfg_t        cfg,
	output logic        out_free,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata
);

	logic signed [VALUE_W-1:0] x_q, v_q, xm_q, vm_q, t_q;
	logic [VALUE_W-1:0]        a_mag, b_mag, b_raw_mag;
	logic signed [VALUE_W-1:0] b_val;
	logic                      a_neg, b_neg;
	logic [2*VALUE_W-1:0]      prod_raw;
	logic [PROD_W-1:0]         prod_rnd, prod_s1, shifted;
	logic                      neg_s1;
	logic [VALUE_W-1:0]        lim, msat;
	logic signed [VALUE_W:0]   term;
	logic signed [VALUE_W-1:0] base, result;
	logic signed [VALUE_W+1:0] sum;
	logic signed [VALUE_W-1:0] pos_q, vel_q;
	logic                      settled_q, valid_q, settled_now;

	// Operand select
	always_comb begin
		a_mag = '0;
		a_neg = 1'b0;
		unique case (cmd.op.a_sel)
			A_DT:    a_mag = VALUE_W'(cfg.time_step);
			A_DRAG:  a_mag = cfg.drag_coef;
			A_STIFF: a_mag = cfg.stiffness_coef;
			A_V: begin
				a_mag = mag(v_q);
				a_neg = v_q[VALUE_W-1];
			end
			A_VM: begin
				a_mag = mag(vm_q);
				a_neg = vm_q[VALUE_W-1];
			end
			default: ;
		endcase

		unique case (cmd.op.b_sel)
			B_T:     b_val = t_q;
			B_X:     b_val = x_q;
			B_XM:    b_val = xm_q;
			B_V:     b_val = v_q;
			B_VM:    b_val = vm_q;
			default: b_val = t_q;
		endcase
		b_raw_mag = mag(b_val);
		if (cmd.op.b_abs) begin
			// |most negative| does not fit: clamp to the positive limit
			b_mag = b_raw_mag[VALUE_W-1] ? VALUE_W'(VAL_MAX) : b_raw_mag;
			b_neg = 1'b0;
		end else begin
			b_mag = b_raw_mag;
			b_neg = b_val[VALUE_W-1];
		end
	end

	assign prod_raw = a_mag * b_mag;
	assign prod_rnd = {1'b0, prod_raw} + (cmd.op.half_step ? RND_HALF : RND_FULL);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= prod_rnd;
			neg_s1  <= a_neg ^ b_neg;
		end
	end

	// Shift, saturate the signed product, then saturating add into the base
	always_comb begin
		shifted = cmd.op.half_step ? (prod_s1 >> (FRAC_BITS + 1)) : (prod_s1 >> FRAC_BITS);
		lim     = neg_s1 ? VALUE_W'(VAL_MIN) : VALUE_W'(VAL_MAX);
		msat    = (shifted > PROD_W'(lim)) ? lim : shifted[VALUE_W-1:0];
		term    = neg_s1 ? -$signed({1'b0, msat}) : $signed({1'b0, msat});

		unique case (cmd.op.base_sel)
			BS_ZERO: base = '0;
			BS_T:    base = t_q;
			BS_V:    base = v_q;
			BS_X:    base = x_q;
			default: base = '0;
		endcase

		if (cmd.op.sub)
			sum = (VALUE_W+2)'(base) - (VALUE_W+2)'(term);
		else
			sum = (VALUE_W+2)'(base) + (VALUE_W+2)'(term);

		if (sum > (VALUE_W+2)'(VAL_MAX))
			result = VAL_MAX;
		else if (sum < (VALUE_W+2)'(VAL_MIN))
			result = VAL_MIN;
		else
			result = sum[VALUE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= RST_START_POS;
			v_q <= RST_START_VEL;
		end else if (cmd.load_start) begin
			x_q <= cfg.start_position;
			v_q <= cfg.start_velocity;
		end else if (cmd.fin_en) begin
			if (cmd.op.dst == D_X)
				x_q <= result;
			if (cmd.op.dst == D_V)
				v_q <= result;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_en) begin
			unique case (cmd.op.dst)
				D_T:     t_q  <= result;
				D_VM:    vm_q <= result;
				D_XM:    xm_q <= result;
				default: ;
			endcase
		end
	end

	assign settled_now = (mag(x_q) < {1'b0, cfg.settle_threshold})
		&& (mag(v_q) < {1'b0, cfg.settle_threshold});

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.out_load)
			valid_q <= 1'b1;
		else if (m_axis_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pos_q     <= x_q;
			vel_q     <= v_q;
			settled_q <= settled_now;
		end
	end

	assign out_free      = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {7'b0, settled_q, vel_q, pos_q};

endmodule

>>> tb/drag_oscillator_midpoint_step_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// drag_oscillator_midpoint_step_unit_tb
// Drives restart/step ticks into the oscillator step unit, reprograms its
// coefficients over APB between phases, and checks every position, velocity
// and settled result against a bit-exact midpoint step predictor kept here.
// ----------------------------------------------------------------------------
module drag_oscillator_midpoint_step_unit_tb;

	localparam int          FB          = dosc_pkg::FRAC_BITS;
	localparam longint      VMAX        = 64'sh7FFF_FFFF;
	localparam longint      VMIN        = -VMAX - 1;
	localparam int          CYCLE_LIMIT = 400000;
	localparam logic [2:0]  REG_SPARE   = 3'd6;  // unmapped register slot

	typedef struct packed {
		logic        settled;
		logic [31:0] vel;
		logic [31:0] pos;
	} osc_result_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;  // [0] restart
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;       // [31:0] position_out, [63:32] velocity_out, [64] settled
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [4:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	drag_oscillator_midpoint_step_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always #2 clk = ~clk;

	// Predictor copy of the registers and the oscillator state
	logic [31:0] drag_q      = dosc_pkg::RST_DRAG;
	logic [31:0] stiff_q     = dosc_pkg::RST_STIFF;
	logic [15:0] dt_q        = dosc_pkg::RST_DT;
	logic [31:0] start_pos_q = dosc_pkg::RST_START_POS;
	logic [31:0] start_vel_q = dosc_pkg::RST_START_VEL;
	logic [30:0] thresh_q    = dosc_pkg::RST_THRESH;
	longint      pos_q       = dosc_pkg::RST_START_POS;
	longint      vel_q       = dosc_pkg::RST_START_VEL;

	bit          tick_q[$];            // restart flag of each tick not yet sent
	osc_result_t expected_state_q[$];  // predicted state per accepted tick

	bit idle_on = 1'b1;
	int feed_gap, drain_gap;
	int ticks_sent, restarts_sent, results_checked, settled_seen;
	int reg_writes, settings_applied, mismatches, cycle_count;

	function automatic longint clamp_val(input longint a);
		if (a > VMAX) return VMAX;
		if (a < VMIN) return VMIN;
		return a;
	endfunction

	function automatic longint abs_val(input longint a);
		return (a < 0) ? -a : a;
	endfunction

	// Exact product, shift with rounding half away from zero, saturate
	function automatic longint scaled_product(input longint a, input longint b, input int sh);
		logic [127:0] prod;
		logic [127:0] mres;
		logic         flip;
		flip = (a < 0) != (b < 0);
		prod = 128'(abs_val(a)) * 128'(abs_val(b));
		mres = (prod + (128'd1 << (sh - 1))) >> sh;
		if (flip) begin
			if (mres > 128'h8000_0000) return VMIN;
			return -longint'(mres[63:0]);
		end
		if (mres > 128'h7FFF_FFFF) return VMAX;
		return longint'(mres[63:0]);
	endfunction

	function automatic longint accel_of(input longint x, input longint v);
		longint vabs, vv, drag_term, spring_term;
		vabs = abs_val(v);
		if (vabs > VMAX) vabs = VMAX;
		vv          = scaled_product(v, vabs, FB);
		drag_term   = scaled_product(longint'(drag_q), vv, FB);
		spring_term = scaled_product(longint'(stiff_q), x, FB);
		return clamp_val(clamp_val(-drag_term) - spring_term);
	endfunction

	function automatic osc_result_t advance_oscillator(input bit restart);
		osc_result_t r;
		longint      dt, acc, vm, xm, am;
		if (restart) begin
			pos_q = longint'($signed(start_pos_q));
			vel_q = longint'($signed(start_vel_q));
		end else begin
			dt    = longint'(dt_q);
			acc   = accel_of(pos_q, vel_q);
			vm    = clamp_val(vel_q + scaled_product(dt, acc, FB + 1));
			xm    = clamp_val(pos_q + scaled_product(dt, vel_q, FB + 1));
			am    = accel_of(xm, vm);
			vel_q = clamp_val(vel_q + scaled_product(dt, am, FB));
			pos_q = clamp_val(pos_q + scaled_product(dt, vm, FB));
		end
		r.pos     = pos_q[31:0];
		r.vel     = vel_q[31:0];
		r.settled = (abs_val(pos_q) < longint'(thresh_q)) && (abs_val(vel_q) < longint'(thresh_q));
		return r;
	endfunction

	task automatic report(input string what, input logic [64:0] want, input logic [64:0] got);
		if (mismatches < 100)
			$display("ERROR %s: expected %h, got %h", what, want, got);
		mismatches++;
	endtask

	// Input side: feed ticks, predict each one as its transaction completes
	always @(posedge clk or negedge arst_n) begin : feed
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			feed_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_state_q.push_back(advance_oscillator(s_axis_tdata[0]));
				ticks_sent++;
				if (s_axis_tdata[0]) restarts_sent++;
			end
			// hold an offered tick until it is taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (feed_gap != 0) begin
					feed_gap      <= feed_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					feed_gap      <= $urandom_range(0, 4);
					s_axis_tvalid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					s_axis_tdata  <= {7'b0, tick_q.pop_front()};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output side: random back-pressure while idle_on is set, compare each result
	always @(posedge clk or negedge arst_n) begin : drain
		osc_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			drain_gap     <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_state_q.size() == 0) begin
					report("result with no tick pending", '0, m_axis_tdata[64:0]);
				end else begin
					want = expected_state_q.pop_front();
					if (m_axis_tdata[31:0] !== want.pos)
						report("position_out", 65'(want.pos), 65'(m_axis_tdata[31:0]));
					if (m_axis_tdata[63:32] !== want.vel)
						report("velocity_out", 65'(want.vel), 65'(m_axis_tdata[63:32]));
					if (m_axis_tdata[64] !== want.settled)
						report("settled", 65'(want.settled), 65'(m_axis_tdata[64]));
					results_checked++;
					if (want.settled) settled_seen++;
				end
			end
			if (!idle_on) begin
				m_axis_tready <= 1'b1;
			end else if (drain_gap != 0) begin
				drain_gap     <= drain_gap - 1;
				m_axis_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				drain_gap     <= $urandom_range(0, 4);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("drag_oscillator_midpoint_step_unit_tb failed");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			dosc_pkg::REG_DRAG:      drag_q      = value;
			dosc_pkg::REG_STIFF:     stiff_q     = value;
			dosc_pkg::REG_DT:        dt_q        = value[15:0];
			dosc_pkg::REG_START_POS: start_pos_q = value;
			dosc_pkg::REG_START_VEL: start_vel_q = value;
			dosc_pkg::REG_THRESH:    thresh_q    = value[30:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic apply_settings(input logic [31:0] drag, input logic [31:0] stiff,
			input logic [31:0] dt, input logic [31:0] spos, input logic [31:0] svel,
			input logic [31:0] thresh);
		apb_write(dosc_pkg::REG_DRAG, drag);
		apb_write(dosc_pkg::REG_STIFF, stiff);
		apb_write(dosc_pkg::REG_DT, dt);
		apb_write(dosc_pkg::REG_START_POS, spos);
		apb_write(dosc_pkg::REG_START_VEL, svel);
		apb_write(dosc_pkg::REG_THRESH, thresh);
		settings_applied++;
	endtask

	function automatic logic [31:0] rand_span(input int unsigned half);
		return $urandom_range(0, 2 * half) - half;
	endfunction

	task automatic random_settings();
		logic [31:0]  d, s, t, p, v, h;
		int unsigned  lim;
		case ($urandom_range(0, 3))
			0: begin  // plausible physics, amplitude up to 10
				d = $urandom_range(0, 32'h2_0000);
				s = $urandom_range(32'h4000, 32'h4_0000);
				t = $urandom_range(1000, 20000);
				p = rand_span(655360);
				v = rand_span(655360);
				h = $urandom_range(0, 32'h2_0000);
			end
			1: begin
				d = $urandom;
				s = $urandom;
				t = $urandom;
				p = $urandom;
				v = $urandom;
				h = $urandom;
			end
			2: begin  // stiff and coarse: drives the sums into saturation
				d = $urandom_range(0, 32'h10_0000);
				s = $urandom_range(32'h1_0000, 32'h400_0000);
				t = $urandom_range(32'h8000, 32'hFFFF);
				p = $urandom;
				v = $urandom;
				h = $urandom_range(0, 32'h7FFF_FFFF);
			end
			default: begin  // start near rest so the settled flag toggles
				lim = $urandom_range(32'h100, 32'h4_0000);
				d = $urandom_range(32'h1_0000, 32'h10_0000);
				s = $urandom_range(32'h1000, 32'h4_0000);
				t = $urandom_range(2000, 30000);
				p = rand_span(2 * lim);
				v = rand_span(2 * lim);
				h = lim;
			end
		endcase
		apply_settings(d, s, t, p, v, h);
	endtask

	// R restarts, S steps
	task automatic push_ticks(input string pattern);
		foreach (pattern[i]) tick_q.push_back(pattern[i] == "R");
	endtask

	task automatic queue_ticks(input int n);
		repeat (n) tick_q.push_back($urandom_range(0, 24) == 0);
	endtask

	// Wait until every tick is sent and every result is back; sample at the
	// falling edge so the driver's updates from the rising edge are visible
	task automatic settle_down();
		while (tick_q.size() != 0 || s_axis_tvalid || expected_state_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_ticks("SSSRS");
		settle_down();
		apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_ticks("RSSS");
		settle_down();
		apply_settings(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		push_ticks("RSS");
		settle_down();
		apply_settings(dosc_pkg::RST_DRAG, dosc_pkg::RST_STIFF, 32'(dosc_pkg::RST_DT),
			32'h0, 32'h0, 32'h1);
		apb_write(REG_SPARE, $urandom);
		push_ticks("RSS");
		settle_down();
		// new start values must not disturb the state before a restart
		apply_settings(32'h1_0000, 32'h1_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h2);
		push_ticks("SRSS");
		settle_down();
		apply_settings(dosc_pkg::RST_DRAG, dosc_pkg::RST_STIFF, 32'(dosc_pkg::RST_DT),
			32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
		push_ticks("RS");
		settle_down();

		for (int phase = 0; phase < 11; phase++) begin
			idle_on = (phase != 10) && ($urandom_range(0, 3) != 0);
			random_settings();
			queue_ticks(163);
			settle_down();
		end

		repeat (24) @(posedge clk);
		$display("Ran %0d ticks (%0d restarts) over %0d register settings, %0d writes.",
			ticks_sent, restarts_sent, settings_applied, reg_writes);
		$display("Checked %0d results, %0d of them settled, %0d mismatches.",
			results_checked, settled_seen, mismatches);
		if (mismatches == 0) begin
			$display("drag_oscillator_midpoint_step_unit_tb passed");
		end else begin
			$display("drag_oscillator_midpoint_step_unit_tb failed");
		end
		$finish;
	end

endmodule

>>> drag_oscillator_midpoint_step_unit.f
sv/dosc_pkg.sv
sv/dosc_cfg.sv
sv/dosc_ctrl.sv
sv/dosc_dp.sv
sv/drag_oscillator_midpoint_step_unit.sv
tb/drag_oscillator_midpoint_step_unit_tb.sv
